>>> rtl/core/assert_macros.svh
// Assertion macros shared by the line search RTL.
// Standalone header; every macro samples on i_clk, and LICS_ASSERT also uses i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LICS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/lics_pkg.sv
// Types, constants and helpers for the line index search block.
// No dependencies.
package lics_pkg;

    localparam int unsigned POS_W     = 18;
    localparam int unsigned POS_MAX   = 262143;
    localparam int unsigned LIM_W     = 21;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned PLEN_W    = 5;
    localparam int unsigned LIMIT_W   = 16;

    localparam int unsigned TEXT_BYTES_DEF    = 262144;
    localparam int unsigned INDEX_SLOTS_DEF   = 32768;
    localparam int unsigned PATTERN_BYTES_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_DELTA = CH_LOWER_A - CH_UPPER_A;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_LIMIT    = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0] line_number;
        logic [POS_W-1:0] start_offset;
        logic [POS_W-1:0] content_length;
        logic             pattern_found;
        logic             within_index;
    } t_out_word;

    // control common to every match cell
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/line_index_ci_search.sv
// Line splitter with a case-insensitive pattern test, one text byte per word.
//
// Input channel: i_in_valid / o_in_stall carry i_in_word (text byte plus a
// final-byte flag). A word is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_out_word, one word per
// closed line (CR, LF, CR LF, or the last byte of the text). The LF of a
// CR LF pair gives no word.
// Result: the word for the byte that closes a line is registered into the output
// register, or into the skid slot while an output word waits. Throughput: one byte
// per cycle while o_in_stall is low; the match row of PATTERN_BYTES cells shifts once per data byte.
// Stall: an output register and a skid slot sit behind the logic; o_in_stall
// rises only when the skid slot holds a word, so one more byte is taken while
// a result waits.
// Reset (synchronous, i_rst_n low): stream state clears, pattern registers go
// to zero and the index limit to 32768. No clearing pass is needed.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index. The user must write only
// while idle; the block does not enforce it. Depends on lics_pkg, lics_chain, lics_skid and assert_macros.svh.
`include "assert_macros.svh"

module line_index_ci_search #(
    parameter int unsigned TEXT_BYTES    = lics_pkg::TEXT_BYTES_DEF,
    parameter int unsigned INDEX_SLOTS   = lics_pkg::INDEX_SLOTS_DEF,
    parameter int unsigned PATTERN_BYTES = lics_pkg::PATTERN_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lics_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lics_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [lics_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lics_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned SAT_INT = (TEXT_BYTES - 1 > lics_pkg::POS_MAX) ?
                                      lics_pkg::POS_MAX : TEXT_BYTES - 1;
    localparam logic [lics_pkg::POS_W-1:0] SAT_MAX = lics_pkg::POS_W'(SAT_INT);
    localparam logic [lics_pkg::LIM_W-1:0] SLOTS   = lics_pkg::LIM_W'(INDEX_SLOTS);

    function automatic logic [lics_pkg::POS_W-1:0] sat_inc(
        input logic [lics_pkg::POS_W-1:0] v
    );
        return (v >= SAT_MAX) ? SAT_MAX : v + 1'b1;
    endfunction

    // configuration
    logic [63:0]                     r_pat_lo;
    logic [63:0]                     r_pat_hi;
    logic [lics_pkg::PLEN_W-1:0]     r_pat_len;
    logic [lics_pkg::LIMIT_W-1:0]    r_limit;

    // stream state
    logic [lics_pkg::POS_W-1:0]      r_pos;
    logic [lics_pkg::POS_W-1:0]      r_start;
    logic [lics_pkg::POS_W-1:0]      r_line;
    logic                            r_cr;
    logic                            r_hit;

    logic                            accept;
    logic                            skid_full;
    logic [7:0]                      c;
    logic                            fin;
    logic                            is_cr;
    logic                            is_lf;
    logic                            swallow;
    logic                            term;
    logic                            is_data;
    logic                            emit;
    logic                            hit_now;
    logic                            pat_empty;
    logic [lics_pkg::POS_W-1:0]      pos_inc;
    logic [lics_pkg::POS_W-1:0]      close_pos;
    logic [lics_pkg::LIM_W-1:0]      lim;
    lics_pkg::t_cell_ctl             cell_ctl;
    lics_pkg::t_out_word             res;

    assign o_in_stall = skid_full;
    assign accept     = i_in_valid && !skid_full;
    assign c          = i_in_word.text_byte;
    assign fin        = i_in_word.final_byte;
    assign is_cr      = (c == lics_pkg::CH_CR);
    assign is_lf      = (c == lics_pkg::CH_LF);
    assign swallow    = is_lf && r_cr;
    assign term       = (is_cr || is_lf) && !swallow;
    assign is_data    = !(is_cr || is_lf);
    assign emit       = term || (is_data && fin);
    assign pos_inc    = sat_inc(r_pos);

    assign cell_ctl.clear = accept && (term || fin);
    assign cell_ctl.shift = accept && is_data;

    always_comb begin
        lim = (lics_pkg::LIM_W'(r_limit) > SLOTS) ? SLOTS : lics_pkg::LIM_W'(r_limit);
        close_pos = term ? r_pos : pos_inc;
        res.line_number    = r_line;
        res.start_offset   = r_start;
        res.content_length = (close_pos >= r_start) ? close_pos - r_start : '0;
        res.pattern_found  = r_hit || (is_data && hit_now) || pat_empty;
        res.within_index   = (lics_pkg::LIM_W'(r_line) < lim);
    end

    lics_chain #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cell_ctl),
        .i_byte    (c),
        .i_pat_lo  (r_pat_lo),
        .i_pat_hi  (r_pat_hi),
        .i_pat_len (r_pat_len),
        .o_hit_now (hit_now),
        .o_empty   (pat_empty)
    );

    lics_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && emit),
        .i_word  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_limit   <= lics_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lics_pkg::CFG_PATTERN_LOW:    r_pat_lo  <= i_cfg_data;
                lics_pkg::CFG_PATTERN_HIGH:   r_pat_hi  <= i_cfg_data;
                lics_pkg::CFG_PATTERN_LENGTH: r_pat_len <= i_cfg_data[lics_pkg::PLEN_W-1:0];
                lics_pkg::CFG_INDEX_LIMIT:    r_limit   <= i_cfg_data[lics_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= '0;
            r_cr    <= 1'b0;
            r_hit   <= 1'b0;
        end else if (accept) begin
            if (fin) begin
                // end of text: start over for the next one
                r_pos   <= '0;
                r_start <= '0;
                r_line  <= '0;
                r_cr    <= 1'b0;
                r_hit   <= 1'b0;
            end else begin
                r_pos <= pos_inc;
                if (swallow) begin
                    r_cr    <= 1'b0;
                    r_start <= pos_inc;
                end else if (term) begin
                    r_line  <= sat_inc(r_line);
                    r_start <= pos_inc;
                    r_cr    <= is_cr;
                    r_hit   <= 1'b0;
                end else begin
                    r_cr  <= 1'b0;
                    r_hit <= r_hit || hit_now;
                end
            end
        end
    end

    `LICS_ASSERT(a_start_le_pos, r_start <= r_pos, "line start beyond byte position")
    `LICS_ASSERT(a_line_sat, r_line <= SAT_MAX, "line number beyond saturation")
    `LICS_ASSERT(a_emit_shows, (accept && emit) |=> o_out_valid,
        "closed line gave no result word")

endmodule

>>> rtl/core/lics_cell.sv
// One match cell: holds "pattern bytes 0..k match the latest bytes of the line".
// Depends on lics_pkg.
module lics_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lics_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_pat_byte,
    input  logic                i_prev_match,
    output logic                o_match,
    output logic                o_match_next
);

    logic r_match;

    assign o_match_next = i_prev_match && (i_byte == i_pat_byte);
    assign o_match      = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.clear) begin
            r_match <= 1'b0;
        end else if (i_ctl.shift) begin
            r_match <= o_match_next;
        end
    end

endmodule

>>> rtl/core/lics_chain.sv
// Row of match cells; each passes its partial match to the next cell.
// Depends on lics_pkg and lics_cell.
module lics_chain #(
    parameter int unsigned PATTERN_BYTES = lics_pkg::PATTERN_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lics_pkg::t_cell_ctl           i_ctl,
    input  logic [7:0]                    i_byte,
    input  logic [63:0]                   i_pat_lo,
    input  logic [63:0]                   i_pat_hi,
    input  logic [lics_pkg::PLEN_W-1:0]   i_pat_len,
    output logic                          o_hit_now,
    output logic                          o_empty
);

    logic [127:0]             pat_all;
    logic [7:0]               byte_f;
    logic [PATTERN_BYTES-1:0] match;
    logic [PATTERN_BYTES-1:0] match_next;
    logic [PATTERN_BYTES-1:0] prev;

    assign pat_all = {i_pat_hi, i_pat_lo};
    assign byte_f  = lics_pkg::fold_byte(i_byte);
    assign o_empty = (i_pat_len == '0);

    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign prev[k] = 1'b1;
        end else begin : g_body
            assign prev[k] = match[k-1];
        end

        lics_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_byte       (byte_f),
            .i_pat_byte   (lics_pkg::fold_byte(pat_all[8*k +: 8])),
            .i_prev_match (prev[k]),
            .o_match      (match[k]),
            .o_match_next (match_next[k])
        );
    end

    // pick the cell that closes a full-length match; longer lengths use the last cell
    always_comb begin
        o_hit_now = 1'b0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            if ((i_pat_len == lics_pkg::PLEN_W'(k + 1)) ||
                ((k == PATTERN_BYTES - 1) && (i_pat_len > lics_pkg::PLEN_W'(PATTERN_BYTES))))
            begin
                o_hit_now = o_hit_now | match_next[k];
            end
        end
    end

endmodule

>>> rtl/core/lics_skid.sv
// Output register plus skid slot for the result words.
// Depends on lics_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lics_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lics_pkg::t_out_word i_word,
    output logic                o_full,
    output logic                o_valid,
    output lics_pkg::t_out_word o_word,
    input  logic                i_stall
);

    logic                r_out_valid;
    logic                r_skid_valid;
    lics_pkg::t_out_word r_out;
    lics_pkg::t_out_word r_skid;
    logic                take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid || take) begin
                r_out       <= i_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_word;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    `LICS_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid word without output word")
    `LICS_ASSERT(a_no_load_full, i_load |-> !r_skid_valid, "word loaded while skid slot full")
    `LICS_ASSERT(a_skid_drains, (r_skid_valid && take) |=> (r_out_valid && !r_skid_valid),
        "skid word not moved to output")

endmodule
